/* rtl/core/pts_pkg.sv */
// Shared types, sizes and codes for the priority timed task scheduler.
// No dependencies; the top level priority_timed_task_scheduler imports this package.
package pts_pkg;

  localparam int READY_DEPTH     = 64;
  localparam int DELAYED_DEPTH   = 64;
  localparam int PRIORITY_LEVELS = 8;
  localparam int MAX_DISPATCH    = 16;
  localparam int RESULT_CAP      = 16;
  localparam int DISP_CAP = (MAX_DISPATCH < RESULT_CAP) ? MAX_DISPATCH : RESULT_CAP;

  localparam int R_AW = $clog2(READY_DEPTH);
  localparam int R_CW = $clog2(READY_DEPTH + 1);
  localparam int D_AW = $clog2(DELAYED_DEPTH);
  localparam int D_CW = $clog2(DELAYED_DEPTH + 1);
  localparam int PW   = (R_CW > D_CW) ? R_CW : D_CW;
  localparam int NW   = $clog2(RESULT_CAP + 1);

  typedef enum logic [1:0] {
    K_POST     = 2'd0,
    K_CANCEL   = 2'd1,
    K_DISPATCH = 2'd2,
    K_NONE     = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_PRIO  = 3'd1,
    ST_NO_HANDLE = 3'd2,
    ST_TIME_OVF  = 3'd3,
    ST_FULL      = 3'd4,
    ST_NONE_RDY  = 3'd5,
    ST_NOT_FOUND = 3'd6
  } status_t;

  // Ready store entry
  typedef struct packed {
    logic [31:0] handle;
    logic [3:0]  prio;
    logic [31:0] tag;
  } rent_t;

  // Delayed store entry
  typedef struct packed {
    logic [47:0] due;
    logic [31:0] handle;
    logic [3:0]  prio;
    logic [31:0] tag;
  } dent_t;

  typedef enum logic [4:0] {
    S_IDLE, S_POST, S_DCHK,
    S_RINS, S_RINS_EV, S_DINS, S_DINS_EV,
    S_RREM, S_RREM_EV, S_DREM, S_DREM_EV,
    S_RSRCH, S_RSRCH_EV, S_DSRCH, S_DSRCH_EV,
    S_DISP, S_PROM_EV, S_HEAD, S_HEAD_EV,
    S_FAULT, S_FINISH, S_RET
  } state_t;

  // Where to resume once an insert or remove walk completes
  typedef enum logic [1:0] {
    C_POST, C_CANCEL, C_PROM_INS, C_DISP
  } cont_t;

endpackage

/* rtl/core/priority_timed_task_scheduler.sv */
// Top level of the priority timed task scheduler: control sequencer and both stores.
// Depends on pts_pkg and pts_ram.
//
//  channel   | handshake          | payload
//  ----------+--------------------+-------------------------------------------------
//  request   | start / busy       | kind now_time time_value time_is_relative
//            |                    | priority_req task_tag task_handle dispatch_limit
//  result    | strobe (no stall)  | status handle_out tag_out priority_out last
//
// One request at a time; busy drops at the edge that puts the last result out.
// Each store step reads an entry, then compares and writes back, so a post or cancel
// walks over the stored entries; a dispatch adds a head-removal
// walk per emitted task and an insert plus remove walk per promoted task.
// rst is synchronous; it clears the counts and the sequencer and sets the handle counter to 1; store
// contents are never read above their count and need no clearing.
module priority_timed_task_scheduler (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind,
  input  logic [47:0] now_time,
  input  logic [47:0] time_value,
  input  logic        time_is_relative,
  input  logic [3:0]  priority_req,
  input  logic [31:0] task_tag,
  input  logic [31:0] task_handle,
  input  logic [4:0]  dispatch_limit,
  output logic        strobe,
  output logic [2:0]  status,
  output logic [31:0] handle_out,
  output logic [31:0] tag_out,
  output logic [3:0]  priority_out,
  output logic        last
);
  import pts_pkg::*;

  state_t state, state_next;
  cont_t  cont, cont_next;

  // Latched request
  logic [47:0] req_now, req_tval;
  logic        req_rel;
  logic [3:0]  req_prio;
  logic [31:0] req_tag, req_handle;
  logic [NW-1:0] req_cap;

  logic [R_CW-1:0] rcount, rcount_next;
  logic [D_CW-1:0] dcount, dcount_next;
  logic [31:0]     next_handle, next_handle_next;
  logic [PW-1:0]   pos, pos_next;
  logic [NW-1:0]   n, n_next;
  dent_t           ins, ins_next;
  logic            pend_valid, pend_valid_next;
  rent_t           pend, pend_next;

  // Memory ports
  logic            r_we, d_we;
  logic [R_AW-1:0] r_waddr, r_raddr;
  logic [D_AW-1:0] d_waddr, d_raddr;
  rent_t           r_wdata, r_rdata;
  dent_t           d_wdata, d_rdata;

  // Result emission
  logic        emit;
  status_t     e_status;
  logic [31:0] e_handle, e_tag;
  logic [3:0]  e_prio;
  logic        e_last;

  pts_ram #(.W($bits(rent_t)), .D(READY_DEPTH)) u_ready (
    .clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
    .raddr(r_raddr), .rdata(r_rdata)
  );

  pts_ram #(.W($bits(dent_t)), .D(DELAYED_DEPTH)) u_delayed (
    .clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
    .raddr(d_raddr), .rdata(d_rdata)
  );

  // Decisions shared by the sequencer and the datapath
  logic          accept;
  logic [48:0]   sum49;
  logic          post_ovf, post_later, post_bad_prio, post_no_handle, post_full;
  logic [47:0]   post_due;
  logic          disp_bad_prio;
  logic [PW-1:0] pos_m1, pos_p1;
  logic          r_less, d_less, r_rem_done, d_rem_done, r_at_end, d_at_end;
  logic          head_due, r_full;

  assign accept         = start && !busy;
  assign busy           = (state != S_IDLE);
  assign sum49          = {1'b0, req_now} + {1'b0, req_tval};
  assign post_ovf       = req_rel && sum49[48];
  assign post_due       = req_rel ? sum49[47:0] : req_tval;
  assign post_later     = req_rel ? (req_tval != 48'd0) : (req_tval > req_now);
  assign post_bad_prio  = {1'b0, req_prio} >= 5'(PRIORITY_LEVELS);
  assign disp_bad_prio  = post_bad_prio;
  assign post_no_handle = (next_handle == 32'd0) || (&next_handle);
  assign post_full      = post_later ? (dcount >= D_CW'(DELAYED_DEPTH))
                                     : (rcount >= R_CW'(READY_DEPTH));
  assign pos_m1         = pos - PW'(1);
  assign pos_p1         = pos + PW'(1);
  assign r_less = (ins.prio < r_rdata.prio) ||
                  ((ins.prio == r_rdata.prio) && (ins.handle < r_rdata.handle));
  assign d_less = (ins.due < d_rdata.due) ||
                  ((ins.due == d_rdata.due) && ((ins.prio < d_rdata.prio) ||
                   ((ins.prio == d_rdata.prio) && (ins.handle < d_rdata.handle))));
  assign r_rem_done = pos_p1 >= PW'(rcount);
  assign d_rem_done = pos_p1 >= PW'(dcount);
  assign r_at_end   = pos >= PW'(rcount);
  assign d_at_end   = pos >= PW'(dcount);
  assign head_due   = d_rdata.due <= req_now;
  assign r_full     = rcount >= R_CW'(READY_DEPTH);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          case (kind_t'(kind))
            K_POST:     state_next = S_POST;
            K_CANCEL:   state_next = S_RSRCH;
            K_DISPATCH: state_next = S_DCHK;
            default:    state_next = S_IDLE;
          endcase
        end
      end
      S_POST: begin
        if (post_ovf || post_bad_prio || post_no_handle || post_full) state_next = S_IDLE;
        else if (post_later) state_next = S_DINS;
        else state_next = S_RINS;
      end
      S_DCHK:     state_next = disp_bad_prio ? S_IDLE : S_DISP;
      S_RINS:     state_next = (pos == '0) ? S_RET : S_RINS_EV;
      S_RINS_EV:  state_next = r_less ? S_RINS : S_RET;
      S_DINS:     state_next = (pos == '0) ? S_RET : S_DINS_EV;
      S_DINS_EV:  state_next = d_less ? S_DINS : S_RET;
      S_RREM:     state_next = r_rem_done ? S_RET : S_RREM_EV;
      S_RREM_EV:  state_next = S_RREM;
      S_DREM:     state_next = d_rem_done ? S_RET : S_DREM_EV;
      S_DREM_EV:  state_next = S_DREM;
      S_RSRCH:    state_next = r_at_end ? S_DSRCH : S_RSRCH_EV;
      S_RSRCH_EV: state_next = (r_rdata.handle == req_handle) ? S_RREM : S_RSRCH;
      S_DSRCH:    state_next = d_at_end ? S_IDLE : S_DSRCH_EV;
      S_DSRCH_EV: state_next = (d_rdata.handle == req_handle) ? S_DREM : S_DSRCH;
      S_DISP: begin
        if (n >= req_cap) state_next = S_FINISH;
        else if (dcount == '0) state_next = S_HEAD;
        else state_next = S_PROM_EV;
      end
      S_PROM_EV: begin
        if (!head_due) state_next = S_HEAD;
        else if (r_full) state_next = S_FAULT;
        else state_next = S_RINS;
      end
      S_HEAD:     state_next = (rcount == '0) ? S_FINISH : S_HEAD_EV;
      S_HEAD_EV:  state_next = (r_rdata.prio > req_prio) ? S_FINISH : S_RREM;
      S_FAULT:    state_next = pend_valid ? S_FAULT : S_IDLE;
      S_FINISH:   state_next = S_IDLE;
      S_RET: begin
        case (cont) inside
          C_POST, C_CANCEL: state_next = S_IDLE;
          C_PROM_INS:       state_next = S_DREM;
          default:          state_next = S_DISP;
        endcase
      end
      default:    state_next = S_IDLE;
    endcase
  end

  // Datapath, memory controls and result emission
  always_comb begin
    cont_next        = cont;
    rcount_next      = rcount;
    dcount_next      = dcount;
    next_handle_next = next_handle;
    pos_next         = pos;
    n_next           = n;
    ins_next         = ins;
    pend_valid_next  = pend_valid;
    pend_next        = pend;
    r_we = 1'b0; r_waddr = '0; r_wdata = '0; r_raddr = '0;
    d_we = 1'b0; d_waddr = '0; d_wdata = '0; d_raddr = '0;
    emit = 1'b0; e_status = ST_OK; e_handle = '0; e_tag = '0; e_prio = '0; e_last = 1'b1;
    unique case (state)
      S_IDLE: begin
        pos_next        = '0;
        n_next          = '0;
        pend_valid_next = 1'b0;
      end
      S_POST: begin
        // check in order: overflow, priority, handles, room
        if (post_ovf) begin
          emit = 1'b1; e_status = ST_TIME_OVF;
        end else if (post_bad_prio) begin
          emit = 1'b1; e_status = ST_BAD_PRIO;
        end else if (post_no_handle) begin
          emit = 1'b1; e_status = ST_NO_HANDLE;
        end else if (post_full) begin
          emit = 1'b1; e_status = ST_FULL;
        end else begin
          ins_next  = '{due: post_due, handle: next_handle, prio: req_prio, tag: req_tag};
          cont_next = C_POST;
          pos_next  = post_later ? PW'(dcount) : PW'(rcount);
        end
      end
      S_DCHK: begin
        if (disp_bad_prio) begin
          emit = 1'b1; e_status = ST_BAD_PRIO;
        end
      end
      // Sorted insert into the ready store: shift larger entries up by one
      S_RINS: begin
        if (pos == '0) begin
          r_we = 1'b1; r_waddr = '0;
          r_wdata = '{handle: ins.handle, prio: ins.prio, tag: ins.tag};
          rcount_next = rcount + R_CW'(1);
        end else begin
          r_raddr = pos_m1[R_AW-1:0];
        end
      end
      S_RINS_EV: begin
        r_we = 1'b1; r_waddr = pos[R_AW-1:0];
        if (r_less) begin
          r_wdata  = r_rdata;
          pos_next = pos_m1;
        end else begin
          r_wdata = '{handle: ins.handle, prio: ins.prio, tag: ins.tag};
          rcount_next = rcount + R_CW'(1);
        end
      end
      // Sorted insert into the delayed store
      S_DINS: begin
        if (pos == '0) begin
          d_we = 1'b1; d_waddr = '0; d_wdata = ins;
          dcount_next = dcount + D_CW'(1);
        end else begin
          d_raddr = pos_m1[D_AW-1:0];
        end
      end
      S_DINS_EV: begin
        d_we = 1'b1; d_waddr = pos[D_AW-1:0];
        if (d_less) begin
          d_wdata  = d_rdata;
          pos_next = pos_m1;
        end else begin
          d_wdata = ins;
          dcount_next = dcount + D_CW'(1);
        end
      end
      // Remove entry at pos: shift later entries down by one
      S_RREM: begin
        if (r_rem_done) rcount_next = rcount - R_CW'(1);
        else r_raddr = pos_p1[R_AW-1:0];
      end
      S_RREM_EV: begin
        r_we = 1'b1; r_waddr = pos[R_AW-1:0]; r_wdata = r_rdata;
        pos_next = pos_p1;
      end
      S_DREM: begin
        if (d_rem_done) dcount_next = dcount - D_CW'(1);
        else d_raddr = pos_p1[D_AW-1:0];
      end
      S_DREM_EV: begin
        d_we = 1'b1; d_waddr = pos[D_AW-1:0]; d_wdata = d_rdata;
        pos_next = pos_p1;
      end
      // Cancel: search ready store, then delayed store
      S_RSRCH: begin
        if (r_at_end) pos_next = '0;
        else r_raddr = pos[R_AW-1:0];
      end
      S_RSRCH_EV: begin
        if (r_rdata.handle == req_handle) cont_next = C_CANCEL;
        else pos_next = pos_p1;
      end
      S_DSRCH: begin
        if (d_at_end) begin
          emit = 1'b1; e_status = ST_NOT_FOUND;
        end else begin
          d_raddr = pos[D_AW-1:0];
        end
      end
      S_DSRCH_EV: begin
        if (d_rdata.handle == req_handle) cont_next = C_CANCEL;
        else pos_next = pos_p1;
      end
      // Dispatch round: look at the delayed head first
      S_DISP: begin
        d_raddr = '0;
      end
      S_PROM_EV: begin
        if (head_due && !r_full) begin
          ins_next  = d_rdata;
          cont_next = C_PROM_INS;
          pos_next  = PW'(rcount);
        end
      end
      S_HEAD: begin
        r_raddr = '0;
      end
      S_HEAD_EV: begin
        if (r_rdata.prio <= req_prio) begin
          // hold the new task; release the previous one as not last
          if (pend_valid) begin
            emit = 1'b1; e_status = ST_OK; e_handle = pend.handle;
            e_tag = pend.tag; e_prio = pend.prio; e_last = 1'b0;
          end
          pend_valid_next = 1'b1;
          pend_next       = r_rdata;
          n_next          = n + NW'(1);
          pos_next        = '0;
          cont_next       = C_DISP;
        end
      end
      S_FAULT: begin
        emit = 1'b1;
        if (pend_valid) begin
          e_status = ST_OK; e_handle = pend.handle; e_tag = pend.tag;
          e_prio = pend.prio; e_last = 1'b0;
          pend_valid_next = 1'b0;
        end else begin
          e_status = ST_FULL;
        end
      end
      S_FINISH: begin
        emit = 1'b1;
        if (pend_valid) begin
          e_status = ST_OK; e_handle = pend.handle; e_tag = pend.tag; e_prio = pend.prio;
          pend_valid_next = 1'b0;
        end else begin
          e_status = ST_NONE_RDY;
        end
      end
      S_RET: begin
        case (cont)
          C_POST: begin
            emit = 1'b1; e_status = ST_OK; e_handle = next_handle;
            next_handle_next = next_handle + 32'd1;
          end
          C_CANCEL: begin
            emit = 1'b1; e_status = ST_OK; e_handle = req_handle;
          end
          C_PROM_INS: begin
            pos_next  = '0;
            cont_next = C_DISP;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      cont        <= C_POST;
      rcount      <= '0;
      dcount      <= '0;
      next_handle <= 32'd1;
      pend_valid  <= 1'b0;
      strobe      <= 1'b0;
    end else begin
      state       <= state_next;
      cont        <= cont_next;
      rcount      <= rcount_next;
      dcount      <= dcount_next;
      next_handle <= next_handle_next;
      pend_valid  <= pend_valid_next;
      strobe      <= emit;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pos  <= pos_next;
    n    <= n_next;
    ins  <= ins_next;
    pend <= pend_next;
    if (accept) begin
      req_now    <= now_time;
      req_tval   <= time_value;
      req_rel    <= time_is_relative;
      req_prio   <= priority_req;
      req_tag    <= task_tag;
      req_handle <= task_handle;
      req_cap    <= (dispatch_limit > 5'(DISP_CAP)) ? NW'(DISP_CAP) : NW'(dispatch_limit);
    end
    if (emit) begin
      status       <= e_status;
      handle_out   <= e_handle;
      tag_out      <= e_tag;
      priority_out <= e_prio;
      last         <= e_last;
    end
  end

endmodule

/* rtl/core/pts_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module pts_ram #(
  parameter int W = 8,
  parameter int D = 4
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
